@@ rtl/current_profile_point_generator_macros.svh @@
// assertion macros for the profile point generator
`ifndef CURRENT_PROFILE_POINT_GENERATOR_MACROS_SVH
`define CURRENT_PROFILE_POINT_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl");
`define CPG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lbl");
`else
`define CPG_ASSERT(lbl, clk, rst_n, prop)
`define CPG_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ rtl/cpg_pkg.sv @@
`timescale 1ns / 1ps
package cpg_pkg;
    localparam int MaxSegments = 32;
    localparam int MaxPoints = 1024;
    localparam int SegIdxW = $clog2(MaxSegments);
    localparam int SegCntW = $clog2(MaxSegments + 1);

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] TR_STEP = 2'd0;
    localparam logic [1:0] TR_RAMP = 2'd1;
    localparam logic [1:0] TR_HOLD = 2'd2;
    // unused transition code, stored as a step
    localparam logic [1:0] TR_ALT = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO_DUR = 3'd1;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic CFG_NUM_POINTS = 1'b0;
    localparam logic CFG_CURRENT_LIMIT = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  kind;
        logic [14:0] cur;
        logic [15:0] dur;
        logic [9:0]  idx;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] value;
        logic [5:0]  count;
        logic [20:0] total;
        logic [14:0] max_cur;
        logic [14:0] min_cur;
    } t_result;
endpackage

@@ rtl/cpg_front.sv @@
`timescale 1ns / 1ps
`include "current_profile_point_generator_macros.svh"
module cpg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cpg_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output cpg_pkg::t_item o_item
);
    // two entry queue
    cpg_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_wp, r_rp;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rp];

    // map unused transition code to step
    cpg_pkg::t_item n_in;
    always_comb begin
        n_in = i_item;
        if (i_item.kind == cpg_pkg::TR_ALT) n_in.kind = cpg_pkg::TR_STEP;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `CPG_ASSERT(a_no_overflow, i_clk, i_rst_n, r_cnt != 2'd3)
    `CPG_ASSERT(a_full_ptrs, i_clk, i_rst_n, (r_cnt == 2'd1) |-> (r_wp != r_rp))
    `CPG_ASSERT(a_cnt_push, i_clk, i_rst_n, (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
endmodule

@@ rtl/cpg_back.sv @@
`timescale 1ns / 1ps
`include "current_profile_point_generator_macros.svh"
module cpg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [14:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  cpg_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output cpg_pkg::t_result o_res
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_WALK = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    logic [10:0] r_num_points;
    logic [14:0] r_limit;
    logic [5:0]  r_count;
    logic [20:0] r_sum;
    logic [14:0] r_max, r_min;
    logic        r_any;
    cpg_pkg::t_item r_it;
    logic [2:0]  r_status;
    logic [14:0] r_value;

    // segment memory: kind, level, seconds
    logic [32:0] r_mem [cpg_pkg::MaxSegments];
    logic [32:0] r_rd;
    logic [cpg_pkg::SegIdxW-1:0] r_seg;

    // walk registers
    logic [9:0]  r_den;
    logic [30:0] r_tnum;
    logic [20:0] r_start;
    logic [14:0] r_level;
    // ramp math
    logic [25:0] r_d;
    logic [40:0] r_acc;
    logic [25:0] r_p;
    logic [14:0] r_tgt;
    logic [5:0]  r_bit;
    logic [40:0] r_rem;
    logic [14:0] r_quo;

    logic [1:0]  rd_kind;
    logic [14:0] rd_lvl;
    logic [15:0] rd_secs;
    logic [20:0] seg_end;
    logic [14:0] seg_tgt;
    logic [30:0] s_den, e_den;
    logic        hit, last_seg;
    logic [9:0]  idx_sat;
    logic [10:0] np_cl;

    assign rd_kind = r_rd[32:31];
    assign rd_lvl = r_rd[30:16];
    assign rd_secs = r_rd[15:0];
    assign seg_end = r_start + {5'd0, rd_secs};
    assign seg_tgt = (rd_kind == cpg_pkg::TR_HOLD) ? r_level : rd_lvl;
    assign s_den = r_start * r_den;
    assign e_den = seg_end * r_den;
    assign hit = (r_tnum >= s_den) && (r_tnum <= e_den);
    assign last_seg = ({1'b0, r_seg} + 6'd1 >= r_count);

    // point count clamp and index saturation
    always_comb begin
        np_cl = r_num_points;
        if (np_cl < 11'd2) np_cl = 11'd2;
        if (np_cl > 11'(cpg_pkg::MaxPoints)) np_cl = 11'(cpg_pkg::MaxPoints);
        idx_sat = (({1'b0, r_it.idx}) > np_cl - 11'd1) ? 10'(np_cl - 11'd1) : r_it.idx;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_res = '{status: r_status, value: r_value, count: r_count, total: r_sum,
                     max_cur: r_max, min_cur: r_min};

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && i_item.mode == cpg_pkg::MODE_LOAD
            && r_count < 6'(cpg_pkg::MaxSegments))
            r_mem[r_count[cpg_pkg::SegIdxW-1:0]] <=
                {i_item.kind, i_item.cur, i_item.dur};
        r_rd <= r_mem[r_seg];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_num_points <= 11'd400;
            r_limit <= 15'd32000;
            r_count <= '0;
            r_sum <= '0;
            r_max <= '0;
            r_min <= '0;
            r_any <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == cpg_pkg::CFG_NUM_POINTS) r_num_points <= i_cfg_data[10:0];
                else r_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_value <= '0;
                    case (i_item.mode)
                        cpg_pkg::MODE_CLEAR: begin
                            r_status <= cpg_pkg::ST_OK;
                            r_state <= S_OUT;
                            r_count <= '0; r_sum <= '0; r_max <= '0;
                            r_min <= '0; r_any <= 1'b0;
                        end
                        cpg_pkg::MODE_LOAD: begin
                            r_state <= S_OUT;
                            if (r_count >= 6'(cpg_pkg::MaxSegments))
                                r_status <= cpg_pkg::ST_FULL;
                            else if (i_item.cur > r_limit) r_status <= cpg_pkg::ST_OVER_LIMIT;
                            else if (i_item.dur == 16'd0) r_status <= cpg_pkg::ST_ZERO_DUR;
                            else begin
                                r_status <= cpg_pkg::ST_OK;
                                r_count <= r_count + 6'd1;
                                r_sum <= r_sum + {5'd0, i_item.dur};
                                if (i_item.kind != cpg_pkg::TR_HOLD) begin
                                    if (i_item.cur > r_max) r_max <= i_item.cur;
                                    if (!r_any || i_item.cur < r_min) r_min <= i_item.cur;
                                    r_any <= 1'b1;
                                end
                            end
                        end
                        cpg_pkg::MODE_QUERY: begin
                            if (r_count == 6'd0) begin
                                r_status <= cpg_pkg::ST_EMPTY;
                                r_state <= S_OUT;
                            end else begin
                                r_status <= cpg_pkg::ST_OK;
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                            r_status <= cpg_pkg::ST_OK;
                            r_state <= S_OUT;
                        end
                    endcase
                    r_seg <= '0;
                    r_start <= '0;
                    r_level <= '0;
                end
                S_READ: begin
                    r_den <= 10'(np_cl - 11'd1);
                    r_tnum <= {21'd0, idx_sat} * {10'd0, r_sum};
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (hit) begin
                        if (rd_kind == cpg_pkg::TR_RAMP) begin
                            r_d <= {10'd0, rd_secs} * {16'd0, r_den};
                            r_p <= 26'(r_tnum - s_den);
                            r_tgt <= seg_tgt;
                            r_state <= S_MUL;
                        end else begin
                            r_value <= seg_tgt;
                            r_state <= S_OUT;
                        end
                    end else if (last_seg) begin
                        r_value <= seg_tgt;
                        r_state <= S_OUT;
                    end else begin
                        r_start <= seg_end;
                        r_level <= seg_tgt;
                        r_seg <= r_seg + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_MUL: begin
                    // level + (target - level) * p / d as one numerator
                    if (r_tgt >= r_level)
                        r_acc <= ({26'd0, r_level} * {15'd0, r_d})
                                 + ({26'd0, r_tgt - r_level} * {15'd0, r_p});
                    else
                        r_acc <= ({26'd0, r_level} * {15'd0, r_d})
                                 - ({26'd0, r_level - r_tgt} * {15'd0, r_p});
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= 6'd40;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one bit a cycle
                    if ({r_rem[39:0], r_acc[r_bit]} >= {15'd0, r_d}) begin
                        r_rem <= {r_rem[39:0], r_acc[r_bit]} - {15'd0, r_d};
                        if (r_bit < 6'd15) r_quo[r_bit[3:0]] <= 1'b1;
                    end else r_rem <= {r_rem[39:0], r_acc[r_bit]};
                    if (r_bit == 6'd0) r_state <= S_OUT;
                    r_bit <= r_bit - 6'd1;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_DIV && r_bit == 6'd0) r_value <= r_quo
                | (({r_rem[39:0], r_acc[0]} >= {15'd0, r_d}) ? 15'd1 : 15'd0);
        end
    end

    `CPG_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= 6'(cpg_pkg::MaxSegments))
    `CPG_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `CPG_ASSERT(a_min_le_max, i_clk, i_rst_n, r_any |-> (r_min <= r_max))
endmodule

@@ rtl/current_profile_point_generator.sv @@
`timescale 1ns / 1ps
// Current profile point generator.
// Slave channel carries items: clear, load segment or query point (tuser = mode).
// Master channel returns one result beat for every item, in order.
// Config port: i_cfg_we with i_cfg_idx 0 = num_points, 1 = current_limit.
// Clear and load items are registered in the front queue and then in the back end,
// which takes a new item only after the result beat of the last one has been taken.
// A query walks the table segment by segment (memory read, then the
// interval compare); a ramp hit adds a multiply state and a bit-serial
// restoring divide.
// A two beat queue in front lets items arrive while the back end works.
// Reset (synchronous, active low) empties the table and restores
// num_points 400 and current_limit 32000.
// When the receiver stalls the result is held and the queue fills, then
// s_axis_tready drops.
module current_profile_point_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // transition[1:0], target_current[16:2], duration[32:17], point_index[42:33]
    input  logic [47:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // point_value[14:0], segment_count[20:15], total_duration[41:21],
    // max_current[56:42], min_current[71:57]
    output logic [71:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);
    cpg_pkg::t_item in_item, q_item;
    cpg_pkg::t_result res;
    logic q_valid, q_ready;

    assign in_item = '{mode: s_axis_tuser, kind: s_axis_tdata[1:0],
                       cur: s_axis_tdata[16:2], dur: s_axis_tdata[32:17],
                       idx: s_axis_tdata[42:33]};

    cpg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    cpg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {res.min_cur, res.max_cur, res.total, res.count, res.value};
    assign m_axis_tuser = res.status;
endmodule

@@ tb/sv/current_profile_point_generator_tb.sv @@
`timescale 1ns / 1ps
module current_profile_point_generator_tb;

    localparam logic [1:0] MODE_NONE = 2'd3;   // unused mode, answered with status ok and no table change
    localparam int TimeoutCycles = 3000000;
    localparam int DrainCycles = 200;

    typedef struct {
        logic [1:0]  mode;
        logic [1:0]  kind;
        logic [14:0] cur;
        logic [15:0] dur;
        logic [9:0]  idx;
    } t_seg_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [14:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    current_profile_point_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the profile table and registers
    logic [10:0] shadow_points = 11'd400;
    logic [14:0] shadow_limit = 15'd32000;
    logic [1:0]  tbl_kind [cpg_pkg::MaxSegments];
    logic [14:0] tbl_level [cpg_pkg::MaxSegments];
    logic [15:0] tbl_secs [cpg_pkg::MaxSegments];
    int unsigned tbl_count = 0;
    int unsigned tbl_total = 0;
    logic [14:0] tbl_max = '0;
    logic [14:0] tbl_min = '0;
    logic        tbl_any_level = 1'b0;

    t_seg_item          pending_items [$];
    cpg_pkg::t_result   expected_results [$];
    t_seg_item          on_bus;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // profile current at a queried point, exact rational time compare
    function automatic logic [14:0] profile_point(logic [9:0] idx_in);
        longint unsigned n, den, idx, tnum, start, level, stop, tgt, d, p, acc, dur;
        n = shadow_points;
        if (n < 2) n = 2;
        if (n > cpg_pkg::MaxPoints) n = cpg_pkg::MaxPoints;
        idx = idx_in;
        if (idx > n - 1) idx = n - 1;
        den = n - 1;
        tnum = idx * tbl_total;
        start = 0;
        level = 0;
        for (int s = 0; s < tbl_count; s++) begin
            dur = tbl_secs[s];
            stop = start + dur;
            tgt = (tbl_kind[s] == cpg_pkg::TR_HOLD) ? level : tbl_level[s];
            if (tnum >= start * den && tnum <= stop * den) begin
                if (tbl_kind[s] == cpg_pkg::TR_RAMP) begin
                    d = dur * den;
                    p = tnum - start * den;
                    acc = level * d;
                    if (tgt >= level) acc += (tgt - level) * p;
                    else acc -= (level - tgt) * p;
                    return 15'(acc / d);
                end
                return 15'(tgt);
            end
            start = stop;
            level = tgt;
        end
        return 15'(level);
    endfunction

    // apply one item to the shadow table and give the result it causes
    function automatic cpg_pkg::t_result apply_item(t_seg_item it);
        cpg_pkg::t_result r;
        logic [1:0] k;
        r = '0;
        r.status = cpg_pkg::ST_OK;
        k = (it.kind == cpg_pkg::TR_ALT) ? cpg_pkg::TR_STEP : it.kind;
        case (it.mode)
            cpg_pkg::MODE_CLEAR: begin
                tbl_count = 0;
                tbl_total = 0;
                tbl_max = '0;
                tbl_min = '0;
                tbl_any_level = 1'b0;
            end
            cpg_pkg::MODE_LOAD: begin
                if (tbl_count >= cpg_pkg::MaxSegments) r.status = cpg_pkg::ST_FULL;
                else if (it.cur > shadow_limit) r.status = cpg_pkg::ST_OVER_LIMIT;
                else if (it.dur == 0) r.status = cpg_pkg::ST_ZERO_DUR;
                else begin
                    tbl_kind[tbl_count] = k;
                    tbl_level[tbl_count] = it.cur;
                    tbl_secs[tbl_count] = it.dur;
                    tbl_count++;
                    tbl_total += it.dur;
                    if (k != cpg_pkg::TR_HOLD) begin
                        if (it.cur > tbl_max) tbl_max = it.cur;
                        if (!tbl_any_level || it.cur < tbl_min) tbl_min = it.cur;
                        tbl_any_level = 1'b1;
                    end
                end
            end
            cpg_pkg::MODE_QUERY: begin
                if (tbl_count == 0) r.status = cpg_pkg::ST_EMPTY;
                else r.value = profile_point(it.idx);
            end
            default: ;
        endcase
        r.count = 6'(tbl_count);
        r.total = 21'(tbl_total);
        r.max_cur = tbl_max;
        r.min_cur = tbl_min;
        return r;
    endfunction

    // driver: feeds beats from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_results.push_back(apply_item(on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'b0, on_bus.idx, on_bus.dur, on_bus.cur, on_bus.kind};
                    s_axis_tuser <= on_bus.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest expectation
    always @(posedge i_clk) begin
        cpg_pkg::t_result want;
        cpg_pkg::t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.value = m_axis_tdata[14:0];
                got.count = m_axis_tdata[20:15];
                got.total = m_axis_tdata[41:21];
                got.max_cur = m_axis_tdata[56:42];
                got.min_cur = m_axis_tdata[71:57];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h / %h", $time,
                             m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: point_value exp %0d got %0d", $time, want.value, got.value);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: segment_count exp %0d got %0d", $time, want.count, got.count);
                        mismatches++;
                    end
                    if (got.total !== want.total) begin
                        $display("%0t: total_duration exp %0d got %0d", $time, want.total, got.total);
                        mismatches++;
                    end
                    if (got.max_cur !== want.max_cur) begin
                        $display("%0t: max_current exp %0d got %0d", $time, want.max_cur,
                                 got.max_cur);
                        mismatches++;
                    end
                    if (got.min_cur !== want.min_cur) begin
                        $display("%0t: min_current exp %0d got %0d", $time, want.min_cur,
                                 got.min_cur);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TimeoutCycles) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] mode, logic [1:0] kind, logic [14:0] cur,
                            logic [15:0] dur, logic [9:0] idx);
        t_seg_item it;
        it.mode = mode;
        it.kind = kind;
        it.cur = cur;
        it.dur = dur;
        it.idx = idx;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == cpg_pkg::CFG_NUM_POINTS) shadow_points = value[10:0];
        else shadow_limit = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random load: mostly legal segments, some over limit or zero length
    task automatic add_random_load();
        logic [14:0] cur;
        logic [15:0] dur;
        int pick;
        pick = $urandom_range(99);
        cur = (pick < 90) ? 15'($urandom_range(shadow_limit)) : 15'($urandom_range(32767));
        pick = $urandom_range(99);
        if (pick < 80) dur = 16'($urandom_range(1, 200));
        else if (pick < 93) dur = 16'($urandom_range(65535));
        else dur = 16'd0;
        add_item(cpg_pkg::MODE_LOAD, 2'($urandom_range(3)), cur, dur, 10'($urandom));
    endtask

    // one burst: usually a clear, a run of loads, then queries, with some noise
    task automatic add_random_burst(int budget);
        int loads;
        int queries;
        int noise;
        loads = ($urandom_range(9) == 0) ? 34 : $urandom_range(1, 12);
        queries = $urandom_range(3, 12);
        if ($urandom_range(5) != 0) add_item(cpg_pkg::MODE_CLEAR, 2'($urandom),
                                             15'($urandom), 16'($urandom), 10'($urandom));
        for (int i = 0; i < loads && i < budget; i++) add_random_load();
        for (int i = 0; i < queries; i++) begin
            noise = $urandom_range(19);
            if (noise == 0) add_item(MODE_NONE, 2'($urandom), 15'($urandom), 16'($urandom),
                                     10'($urandom));
            else if (noise == 1) add_random_load();
            else add_item(cpg_pkg::MODE_QUERY, 2'($urandom), 15'($urandom), 16'($urandom),
                          10'($urandom_range(1023)));
        end
    endtask

    initial begin
        int points_set [6];
        int limit_set [6];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        send_idle_pct = 11;
        recv_idle_pct = 81;
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_STEP, 15'd32000, 16'd65535, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_RAMP, 15'd0, 16'd1, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_HOLD, 15'd32767, 16'd3, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_HOLD, 15'd500, 16'd3, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_ALT, 15'd100, 16'd2, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_RAMP, 15'd31000, 16'd40000, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_STEP, 15'd32001, 16'd5, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_STEP, 15'd7, 16'd0, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_STEP, 15'd32767, 16'd0, 10'd0);
        add_item(MODE_NONE, cpg_pkg::TR_ALT, 15'h7fff, 16'hffff, 10'h3ff);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd0);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd199);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd250);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd399);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd1023);
        add_item(cpg_pkg::MODE_CLEAR, cpg_pkg::TR_ALT, 15'h7fff, 16'hffff, 10'h3ff);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_RAMP, 15'd32000, 16'd10, 10'd0);
        add_item(cpg_pkg::MODE_LOAD, cpg_pkg::TR_RAMP, 15'd0, 16'd10, 10'd0);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd133);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd301);
        add_item(cpg_pkg::MODE_CLEAR, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd0);
        add_item(cpg_pkg::MODE_QUERY, cpg_pkg::TR_STEP, 15'd0, 16'd0, 10'd5);
        wait_idle();

        // register settings per phase, extremes and clamped point counts included
        points_set = '{2, 1024, 400, 2047, 1, 0};
        limit_set = '{0, 32000, 20000, 32767, 1, 5000};
        for (int ph = 0; ph < 6; ph++) begin
            int budget;
            if (ph < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 81;
            end else if (ph < 4) begin
                send_idle_pct = 81;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(cpg_pkg::CFG_NUM_POINTS, 15'(points_set[ph] == 400 ?
                                          $urandom_range(2, 1024) : points_set[ph]));
            write_reg(cpg_pkg::CFG_CURRENT_LIMIT, 15'(limit_set[ph]));
            budget = 125;
            while (budget > 0) begin
                int before_sz;
                before_sz = pending_items.size();
                add_random_burst(budget);
                budget -= pending_items.size() - before_sz;
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ current_profile_point_generator.f @@
+incdir+rtl
rtl/cpg_pkg.sv
rtl/cpg_front.sv
rtl/cpg_back.sv
rtl/current_profile_point_generator.sv
tb/sv/current_profile_point_generator_tb.sv
